FILE: rtl/sap_pkg.sv
// Package for the shelf atlas packer: word types, register map and placement constants.
package sap_pkg;

  localparam int ATLAS_MAX_WIDTH = 4096;
  localparam int MAX_SLOTS       = 8192;

  localparam int TILE_DIM_W = 13;
  localparam int EXTRA_W    = 12;
  localparam int X_W        = 14;
  localparam int Y_W        = 26;
  localparam int COUNT_W    = 14;
  localparam int CFG_IDX_W  = 1;

  localparam logic [TILE_DIM_W-1:0] TILE_WIDTH_RESET  = 13'd48;
  localparam logic [TILE_DIM_W-1:0] TILE_HEIGHT_RESET = 13'd24;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_TILE_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TILE_HEIGHT = 1'd1;

  // Final status codes.
  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_TOO_MANY = 2'd1;
  localparam logic [1:0] STATUS_EMPTY    = 2'd2;

  typedef struct packed {
    logic [TILE_DIM_W-1:0] tile_width;
    logic [TILE_DIM_W-1:0] tile_height;
  } cfg_t;

  typedef struct packed {
    logic               tile_present;
    logic               has_extra;
    logic [EXTRA_W-1:0] extra_width;
    logic [EXTRA_W-1:0] extra_height;
    logic               last_tile;
  } tile_word_t;

  typedef struct packed {
    logic           placed;
    logic [X_W-1:0] base_x;
    logic [Y_W-1:0] base_y;
    logic           extra_placed;
    logic [X_W-1:0] extra_x;
    logic [Y_W-1:0] extra_y;
    logic           final_result;
    logic [X_W-1:0] atlas_width;
    logic [Y_W-1:0] atlas_height;
    logic [1:0]     status;
  } result_word_t;

endpackage

FILE: rtl/sap_cfg.sv
// Configuration registers of the shelf atlas packer: tile width and tile height.
module sap_cfg
  import sap_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [TILE_DIM_W-1:0] cfg_data,
  output cfg_t                 cfg
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.tile_width  <= TILE_WIDTH_RESET;
      cfg.tile_height <= TILE_HEIGHT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_TILE_WIDTH:  cfg.tile_width  <= cfg_data;
        REG_TILE_HEIGHT: cfg.tile_height <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

FILE: rtl/sap_place.sv
// Shelf placement logic: running cursor state and the result of one tile word.
module sap_place
  import sap_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  cfg_t         cfg,
  input  logic         fire,
  input  tile_word_t   item,
  output result_word_t res
);

  logic [X_W-1:0]        cursor_x,      cursor_x_next;
  logic [Y_W-1:0]        cursor_y,      cursor_y_next;
  logic [TILE_DIM_W-1:0] row_height,    row_height_next;
  logic [X_W-1:0]        widest_extent, widest_extent_next;
  logic [COUNT_W-1:0]    slot_count,    slot_count_next;

  logic [EXTRA_W-1:0]    ew, eh;
  logic                  ew_nz, do_place, wrap;
  logic [X_W:0]          extra_span, pw, span, ext_x, end_x;
  logic [Y_W:0]          wrap_sum, height_sum;
  logic [X_W-1:0]        cx0, cx1;
  logic [Y_W-1:0]        cy0, height;
  logic [TILE_DIM_W-1:0] rh0, ph;

  always_comb begin
    ew    = item.has_extra ? item.extra_width  : '0;
    eh    = item.has_extra ? item.extra_height : '0;
    ew_nz = (ew != '0);

    slot_count_next = (slot_count <= COUNT_W'(MAX_SLOTS)) ? slot_count + 1'b1 : slot_count;
    do_place = item.tile_present && (slot_count_next <= COUNT_W'(MAX_SLOTS));

    extra_span = ew_nz ? (X_W+1)'(ew) + 1'b1 : '0;
    pw         = (X_W+1)'(cfg.tile_width) + 1'b1 + extra_span;
    span       = (X_W+1)'(cursor_x) + pw;
    wrap       = (span > (X_W+1)'(ATLAS_MAX_WIDTH)) && (cursor_x != '0);

    // Wrapping moves down by the row height plus one pixel, saturating.
    wrap_sum = (Y_W+1)'(cursor_y) + (Y_W+1)'(row_height) + 1'b1;
    cx0 = wrap ? '0 : cursor_x;
    cy0 = wrap ? (wrap_sum[Y_W] ? '1 : wrap_sum[Y_W-1:0]) : cursor_y;
    rh0 = wrap ? '0 : row_height;

    ext_x = (X_W+1)'(cx0) + (X_W+1)'(cfg.tile_width) + 1'b1;
    end_x = ext_x + extra_span;
    cx1   = end_x[X_W-1:0];
    ph    = (cfg.tile_height > TILE_DIM_W'(eh)) ? cfg.tile_height : TILE_DIM_W'(eh);

    if (do_place) begin
      cursor_x_next      = cx1;
      cursor_y_next      = cy0;
      row_height_next    = (ph > rh0) ? ph : rh0;
      widest_extent_next = (cx1 > widest_extent) ? cx1 : widest_extent;
    end else begin
      cursor_x_next      = cursor_x;
      cursor_y_next      = cursor_y;
      row_height_next    = row_height;
      widest_extent_next = widest_extent;
    end

    height_sum = (Y_W+1)'(cursor_y_next) + (Y_W+1)'(row_height_next);
    height     = height_sum[Y_W] ? '1 : height_sum[Y_W-1:0];

    res              = '0;
    res.placed       = do_place;
    res.base_x       = do_place ? cx0 : '0;
    res.base_y       = do_place ? cy0 : '0;
    res.extra_placed = do_place && ew_nz;
    res.extra_x      = (do_place && ew_nz) ? ext_x[X_W-1:0] : '0;
    res.extra_y      = (do_place && ew_nz) ? cy0 : '0;
    res.final_result = item.last_tile;
    if (item.last_tile) begin
      if (slot_count_next > COUNT_W'(MAX_SLOTS)) begin
        res.status = STATUS_TOO_MANY;
      end else if (widest_extent_next == '0 || height == '0) begin
        res.status = STATUS_EMPTY;
      end else begin
        res.status       = STATUS_OK;
        res.atlas_width  = widest_extent_next;
        res.atlas_height = height;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cursor_x      <= '0;
      cursor_y      <= '0;
      row_height    <= '0;
      widest_extent <= '0;
      slot_count    <= '0;
    end else if (fire) begin
      if (item.last_tile) begin
        cursor_x      <= '0;
        cursor_y      <= '0;
        row_height    <= '0;
        widest_extent <= '0;
        slot_count    <= '0;
      end else begin
        cursor_x      <= cursor_x_next;
        cursor_y      <= cursor_y_next;
        row_height    <= row_height_next;
        widest_extent <= widest_extent_next;
        slot_count    <= slot_count_next;
      end
    end
  end

endmodule

FILE: rtl/shelf_atlas_packer.sv
// Shelf atlas packer top level: input register, placement logic and result register.
// A tile word is held in the input register and its result word in the result register.
// Throughput: one tile word per cycle unless result_stall holds a result word.
// Every tile word yields exactly one result word.
// Reset (rst, synchronous) clears the cursors, slot count and both pipeline valids;
// tile width and height return to 48 and 24 and are kept across tile sets.
module shelf_atlas_packer
  import sap_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  tile_valid,
  output logic                  tile_stall,
  input  tile_word_t            tile,
  output logic                  result_valid,
  input  logic                  result_stall,
  output result_word_t          result,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [TILE_DIM_W-1:0] cfg_data
);

  cfg_t         cfg;
  tile_word_t   in_q;
  logic         in_q_valid;
  logic         advance;
  logic         fire;
  result_word_t res;

  // The result register moves whenever it is empty or its word is being taken.
  // The input register then hands its word through the placement logic, which
  // also commits the cursor state in the same cycle.
  assign advance    = !result_valid || !result_stall;
  assign fire       = in_q_valid && advance;
  assign tile_stall = in_q_valid && !advance;

  sap_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  sap_place u_place (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .fire (fire),
    .item (in_q),
    .res  (res)
  );

  // Input register: loads a new word whenever it is empty or draining.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (!tile_stall) begin
      in_q_valid <= tile_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!tile_stall) begin
      in_q <= tile;
    end
  end

  // Result register: holds its word while the consumer stalls.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= in_q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      result <= res;
    end
  end

endmodule

FILE: rtl/sap_checker.sv
// Port-level checker for the shelf atlas packer and its bind to the top level.
module sap_checker
  import sap_pkg::*;
(
  input logic         clk,
  input logic         rst,
  input logic         result_valid,
  input logic         result_stall,
  input result_word_t result
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("stalled result word changed");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !result_valid)
    else $error("result valid right after reset");

  a_size_only_ok: assert property (@(posedge clk) disable iff (rst)
    result_valid && (result.status != STATUS_OK || !result.final_result)
      |-> result.atlas_width == '0 && result.atlas_height == '0)
    else $error("atlas size reported without an ok final status");

  a_extra_row: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.extra_placed
      |-> result.placed && result.extra_y == result.base_y)
    else $error("extra rectangle placed off the base row");

  a_unplaced_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.placed
      |-> result.base_x == '0 && result.base_y == '0 && !result.extra_placed)
    else $error("position reported for a tile that was not placed");

endmodule

bind shelf_atlas_packer sap_checker u_sap_checker (
  .clk          (clk),
  .rst          (rst),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .result       (result)
);
